### sv/kmcd_pkg.sv
`default_nettype none

package kmcd_pkg;

  localparam int CHANNELS    = 8;
  localparam int WINDOW      = 64;
  localparam int SAMPLE_BITS = 12;

  localparam int CH_W       = 3;
  localparam int VAL_W      = 16;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 15;
  localparam int DZ_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MEM_DEPTH = CHANNELS * WINDOW;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int RANK      = WINDOW / 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECENT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 15'd256;
  localparam logic [TIME_W-1:0] RECENT_RST    = 32'd200;
  localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 8'd4;

  typedef enum logic [1:0] {
    SEL_CLEAR,
    SEL_IDLE,
    SEL_SWEEP,
    SEL_WAIT
  } sel_state_e;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [TIME_W-1:0] recent;
    logic [DZ_W-1:0]   dead_zone;
  } kmcd_cfg_t;

  typedef struct packed {
    logic             done;
    logic             report;
    logic [CH_W-1:0]  chan;
    logic [VAL_W-1:0] value;
  } kmcd_res_t;

  function automatic logic [ADDR_W-1:0] win_base(input logic [CH_W-1:0] ch);
    return ADDR_W'(int'(ch) * WINDOW);
  endfunction

endpackage

`default_nettype wire

### sv/kmcd_select.sv
`default_nettype none

module kmcd_select (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [kmcd_pkg::CH_W-1:0]        chan_i,
  input  wire logic [kmcd_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                  ready_o,
  output logic                                  done_o,
  output logic [kmcd_pkg::SAMPLE_BITS-1:0]      median_o
);
  import kmcd_pkg::*;

  sel_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] mem_q [MEM_DEPTH];
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] rdata_q;

  logic [ADDR_W-1:0]      clr_addr_q;
  logic [IDX_W-1:0]       slot_q [CHANNELS];
  logic [CH_W-1:0]        chan_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   rd_vld_q;
  logic                   rd_last_q;
  logic                   done_q;

  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       krem_q;
  logic [SAMPLE_BITS-1:0] prefix_q;
  logic [SAMPLE_BITS-1:0] hi_mask_q;
  logic [SAMPLE_BITS-1:0] bit_mask_q;
  logic [SAMPLE_BITS-1:0] median_q;

  logic                   idx_last;
  logic                   match;
  logic [CNT_W-1:0]       cnt_fin;
  logic                   take_one;
  logic [SAMPLE_BITS-1:0] prefix_nxt;
  logic                   bit_done;

  assign idx_last = (idx_q == IDX_W'(WINDOW - 1));

  // element counts below when it agrees with the prefix above this bit and has a zero here
  assign match = (((rdata_q ^ prefix_q) & hi_mask_q) == '0) && ((rdata_q & bit_mask_q) == '0);
  assign cnt_fin    = count_q + CNT_W'(match);
  assign take_one   = (krem_q >= cnt_fin);
  assign prefix_nxt = take_one ? (prefix_q | bit_mask_q) : prefix_q;
  assign bit_done   = rd_vld_q && rd_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEL_CLEAR: begin
        if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) state_d = SEL_IDLE;
      end
      SEL_IDLE: begin
        if (start_i) state_d = SEL_SWEEP;
      end
      SEL_SWEEP: begin
        if (idx_last) state_d = SEL_WAIT;
      end
      SEL_WAIT: begin
        if (bit_done) state_d = bit_mask_q[0] ? SEL_IDLE : SEL_SWEEP;
      end
      default: state_d = SEL_CLEAR;
    endcase
  end

  always_comb begin
    ready_o   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    rd_en     = 1'b0;
    rd_addr   = win_base(chan_q) + ADDR_W'(idx_q);
    case (state_q)
      SEL_CLEAR: begin
        mem_we = 1'b1;
      end
      SEL_IDLE: begin
        ready_o   = 1'b1;
        mem_we    = start_i;
        mem_waddr = win_base(chan_i) + ADDR_W'(slot_q[chan_i]);
        mem_wdata = sample_i;
      end
      SEL_SWEEP: begin
        rd_en = 1'b1;
      end
      SEL_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SEL_CLEAR;
      clr_addr_q <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      done_q     <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) slot_q[c] <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_en;
      rd_last_q <= rd_en && idx_last;
      done_q    <= bit_done && bit_mask_q[0];
      if (state_q == SEL_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      if (state_q == SEL_SWEEP) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
      end
      if (state_q == SEL_IDLE && start_i) begin
        idx_q <= '0;
        slot_q[chan_i] <= (slot_q[chan_i] == IDX_W'(WINDOW - 1)) ? '0
                                                                  : slot_q[chan_i] + 1'b1;
      end
    end
  end

  // rank search, one result bit per sweep of the window, most significant first
  always_ff @(posedge clk_i) begin
    if (state_q == SEL_IDLE && start_i) begin
      chan_q     <= chan_i;
      count_q    <= '0;
      krem_q     <= CNT_W'(RANK);
      prefix_q   <= '0;
      hi_mask_q  <= '0;
      bit_mask_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else if (rd_vld_q) begin
      if (rd_last_q) begin
        count_q    <= '0;
        prefix_q   <= prefix_nxt;
        if (take_one) krem_q <= krem_q - cnt_fin;
        hi_mask_q  <= hi_mask_q | bit_mask_q;
        bit_mask_q <= bit_mask_q >> 1;
        if (bit_mask_q[0]) median_q <= prefix_nxt;
      end else begin
        count_q <= cnt_fin;
      end
    end
  end

  assign done_o   = done_q;
  assign median_o = median_q;

endmodule

`default_nettype wire

### sv/kmcd_decide.sv
`default_nettype none

module kmcd_decide (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [kmcd_pkg::SAMPLE_BITS-1:0] median_i,
  input  wire logic [kmcd_pkg::CH_W-1:0]        chan_i,
  input  wire logic [kmcd_pkg::TIME_W-1:0]      now_i,
  input  wire kmcd_pkg::kmcd_cfg_t              cfg_i,
  input  wire logic                             out_ready_i,
  output kmcd_pkg::kmcd_res_t                   res_o
);
  import kmcd_pkg::*;

  localparam int SCL_W = SAMPLE_BITS + 4;

  logic              a_vld_q, b_vld_q, c_vld_q;
  logic [VAL_W-1:0]  val_q;
  logic [VAL_W-1:0]  diff_q;
  logic [TIME_W-1:0] elapsed_q;

  logic [VAL_W-1:0]  last_val_q  [CHANNELS];
  logic [TIME_W-1:0] last_time_q [CHANNELS];

  logic [SCL_W-1:0]  scaled;
  logic [VAL_W-1:0]  val_sat;
  logic [VAL_W-1:0]  val_d;
  logic [VAL_W-1:0]  last_val;
  logic [VAL_W:0]    thr2;
  logic              report;
  logic              commit;

  assign scaled  = {median_i, 4'b0000};
  assign val_sat = (SCL_W'(scaled) > SCL_W'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : VAL_W'(scaled);
  assign val_d   = (val_sat[VAL_W-1:8] <= cfg_i.dead_zone) ? '0 : val_sat;

  assign last_val = last_val_q[chan_i];
  assign thr2     = (VAL_W+1)'(cfg_i.threshold) << 1;
  assign report   = (diff_q >= VAL_W'(cfg_i.threshold)) &&
                    ((elapsed_q <= cfg_i.recent) || ((VAL_W+1)'(diff_q) >= thr2));
  // hold a report until the output register can take it
  assign commit   = c_vld_q && (!report || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (start_i) val_q <= val_d;
    if (a_vld_q) begin
      diff_q    <= (val_q >= last_val) ? val_q - last_val : last_val - val_q;
      elapsed_q <= now_i - last_time_q[chan_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_val_q[c]  <= '0;
        last_time_q[c] <= '0;
      end
    end else begin
      a_vld_q <= start_i;
      b_vld_q <= a_vld_q;
      if (b_vld_q) c_vld_q <= 1'b1;
      else if (commit) c_vld_q <= 1'b0;
      if (commit && report) begin
        last_val_q[chan_i]  <= val_q;
        last_time_q[chan_i] <= now_i;
      end
    end
  end

  always_comb begin
    res_o.done   = commit;
    res_o.report = report;
    res_o.chan   = chan_i;
    res_o.value  = val_q;
  end

endmodule

`default_nettype wire

### sv/knob_median_change_detector_core.sv
// Path: an accepted item passes the bit-serial rank search in kmcd_select, then the a, b
// and c registers of kmcd_decide and, for a report, the output register behind m_axis_tvalid.
// Throughput: one item at a time, the next accepted only once the last one's result is
// done, set by the bit-serial rank search, one sweep of the window memory's read port per
// bit; a report held behind an unread result stalls the input until that result is taken.
// Reset: asynchronous, active low; afterwards a clearing pass over all CHANNELS*WINDOW (512)
// entries zeroes the window memory while no item is taken; config writes are always taken.
`default_nettype none

module knob_median_change_detector_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // channel[2:0], sample[14:3], now[46:15], zero pad[47]
  input  wire logic [47:0]                        s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // channel_out[2:0], value[18:3], zero pad[23:19]
  output logic [23:0]                             m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [kmcd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [kmcd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import kmcd_pkg::*;

  kmcd_cfg_t         cfg_q;
  logic              busy_q;
  logic [CH_W-1:0]   chan_q;
  logic [TIME_W-1:0] now_q;
  logic              out_vld_q;
  logic [CH_W-1:0]   out_chan_q;
  logic [VAL_W-1:0]  out_val_q;

  logic                   sel_ready;
  logic                   sel_done;
  logic [SAMPLE_BITS-1:0] median;
  logic                   accept;
  logic                   chan_ok;
  logic                   start;
  logic [CH_W-1:0]        in_chan;
  kmcd_res_t              res;

  assign in_chan       = s_axis_tdata[CH_W-1:0];
  assign s_axis_tready = sel_ready && !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // drop items for channels beyond the table
  assign chan_ok       = (int'(in_chan) < CHANNELS);
  assign start         = accept && chan_ok;

  kmcd_select u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .chan_i   (in_chan),
    .sample_i (s_axis_tdata[CH_W +: SAMPLE_BITS]),
    .ready_o  (sel_ready),
    .done_o   (sel_done),
    .median_o (median)
  );

  kmcd_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (sel_done),
    .median_i    (median),
    .chan_i      (chan_q),
    .now_i       (now_q),
    .cfg_i       (cfg_q),
    .out_ready_i (!out_vld_q || m_axis_tready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i) begin
    if (start) begin
      chan_q <= in_chan;
      now_q  <= s_axis_tdata[CH_W + 12 +: TIME_W];
    end
    if (res.done && res.report) begin
      out_chan_q <= res.chan;
      out_val_q  <= res.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.recent    <= RECENT_RST;
      cfg_q.dead_zone <= DEAD_ZONE_RST;
      busy_q          <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[THR_W-1:0];
          REG_RECENT:    cfg_q.recent    <= cfg_data_i[TIME_W-1:0];
          REG_DEAD_ZONE: cfg_q.dead_zone <= cfg_data_i[DZ_W-1:0];
          default: begin
          end
        endcase
      end
      if (start) busy_q <= 1'b1;
      else if (res.done) busy_q <= 1'b0;
      if (res.done && res.report) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b00000, out_val_q, out_chan_q};

endmodule

`default_nettype wire
